// ===== rtl/drt_pkg.sv =====
// Shared types, constants and helpers of the daily relay time switch.
package drt_pkg;

	// Width of the packed channel setup register.
	localparam int SETUP_W = 46;

	// Width of the millisecond counter and of the duration stamps.
	localparam int MS_W = 32;

	// Seconds in the setup register are scaled to milliseconds.
	localparam int MS_PER_S = 1000;

	// First hour value that can never match.
	localparam logic [4:0] HOURS_PER_DAY = 5'd24;

	// Value of the last minute register when no minute has been seen.
	localparam logic [6:0] NO_MINUTE = 7'd127;

	// Packed layout of one channel setup register, most significant field first.
	typedef struct packed {
		logic [21:0] dur_sec;
		logic        dur_mode;
		logic        enable;
		logic [5:0]  end_min;
		logic [4:0]  end_hour;
		logic [5:0]  start_min;
		logic [4:0]  start_hour;
	} setup_t;

	// Commands that one channel lane hands back to the top level.
	typedef struct packed {
		logic turn_on;
		logic turn_off;
		logic stamp_set;
		logic stamp_clr;
	} lane_res_t;

	// A time of day matches only when both hours lie inside the day.
	function automatic logic time_match(input logic [4:0] h, input logic [5:0] m,
			input logic [4:0] rh, input logic [5:0] rm);
		time_match = (h < HOURS_PER_DAY) && (rh < HOURS_PER_DAY) && (h == rh) && (m == rm);
	endfunction

endpackage

// ===== rtl/drt_setup.sv =====
// Channel setup registers and the precomputed duration limits in milliseconds.
module drt_setup import drt_pkg::*; #(
	parameter int CHANNELS  = 8,
	parameter int CFG_IDX_W = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [SETUP_W-1:0]   wr_data,
	output setup_t               setup   [CHANNELS],
	output logic [MS_W-1:0]      limit   [CHANNELS]
);

	setup_t          setup_q [CHANNELS];
	logic [MS_W-1:0] limit_q [CHANNELS];
	setup_t          wr_setup;
	logic [MS_W-1:0] wr_limit;

	// The limit is worked out once at write time; even the largest duration fits in 32 bits.
	always_comb begin
		wr_setup = setup_t'(wr_data);
		wr_limit = MS_W'({10'd0, wr_setup.dur_sec} * MS_W'(MS_PER_S));
	end

	// One register per channel; indexes beyond the channel count are dropped.
	for (genvar i = 0; i < CHANNELS; i++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				setup_q[i] <= '0;
				limit_q[i] <= '0;
			end else if (wr_en && (wr_index == CFG_IDX_W'(i))) begin
				setup_q[i] <= wr_setup;
				limit_q[i] <= wr_limit;
			end
		end
		assign setup[i] = setup_q[i];
		assign limit[i] = limit_q[i];
	end

endmodule

// ===== rtl/drt_lane.sv =====
// Decision logic of one relay channel for one tick.
module drt_lane import drt_pkg::*; (
	input  setup_t          setup,
	input  logic [MS_W-1:0] limit,
	input  logic [MS_W-1:0] stamp,
	input  logic            clock_valid,
	input  logic            new_minute,
	input  logic [4:0]      hour,
	input  logic [5:0]      minute,
	input  logic [MS_W-1:0] now_ms,
	input  logic            relay_on,
	output lane_res_t       res
);

	logic            start_hit;
	logic            end_hit;
	logic [MS_W-1:0] elapsed;
	logic            expired;

	// Matches against the start and end times, and the elapsed on-time.
	always_comb begin
		start_hit = time_match(hour, minute, setup.start_hour, setup.start_min);
		end_hit   = time_match(hour, minute, setup.end_hour, setup.end_min);
		elapsed   = now_ms - stamp;
		expired   = setup.enable && setup.dur_mode && relay_on && (stamp != '0)
			&& (elapsed >= limit);
	end

	// A new minute runs the time matches; the same minute only runs the duration check.
	always_comb begin
		res = '0;
		if (clock_valid) begin
			if (!new_minute) begin
				res.turn_off  = expired;
				res.stamp_clr = expired;
			end else if (setup.enable) begin
				res.turn_on   = start_hit && !relay_on;
				res.stamp_set = start_hit && !relay_on && setup.dur_mode;
				// An end match sees a relay that was just turned on as on.
				res.turn_off  = !setup.dur_mode && end_hit && (relay_on || start_hit);
			end
		end
	end

endmodule

// ===== rtl/daily_relay_time_switch_unit.sv =====
// Top level of the daily relay time switch: input register, channel lanes, result register.
// A result is offered from the result register once its item has moved on from the input register.
// Throughput: one item per cycle while out_stall is low; the input register refills while a result waits.
// The per-channel stamp and last-minute state are updated as an item leaves the input stage.
// Reset clears all setup registers, stamps and pipeline valids, and marks no minute seen.
module daily_relay_time_switch_unit import drt_pkg::*; #(
	parameter int CHANNELS  = 8,
	parameter int CFG_IDX_W = $clog2(CHANNELS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SETUP_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 clock_valid,
	input  logic [4:0]           hour,
	input  logic [5:0]           minute,
	input  logic [MS_W-1:0]      now_ms,
	input  logic [CHANNELS-1:0]  relay_states,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CHANNELS-1:0]  turn_on,
	output logic [CHANNELS-1:0]  turn_off
);

	setup_t              setup  [CHANNELS];
	logic [MS_W-1:0]     limit  [CHANNELS];
	logic [MS_W-1:0]     stamp_q [CHANNELS];
	lane_res_t           res    [CHANNELS];
	logic [CHANNELS-1:0] stamp_set;
	logic [CHANNELS-1:0] stamp_clr;

	logic                vld_s1;
	logic                clock_valid_s1;
	logic [4:0]          hour_s1;
	logic [5:0]          minute_s1;
	logic [MS_W-1:0]     now_ms_s1;
	logic [CHANNELS-1:0] relays_s1;

	logic                vld_s2;
	logic [CHANNELS-1:0] on_s2;
	logic [CHANNELS-1:0] off_s2;

	logic [6:0]          last_minute_q;
	logic                new_minute;
	logic                advance;
	logic                commit;

	// Configuration is always taken.
	assign cfg_ready = 1'b1;

	drt_setup #(
		.CHANNELS  (CHANNELS),
		.CFG_IDX_W (CFG_IDX_W)
	) u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.setup    (setup),
		.limit    (limit)
	);

	// Pipeline flow: the input stage moves on whenever the result register is empty or its result is taken.
	assign advance  = !vld_s2 || !out_stall;
	assign in_stall = vld_s1 && !advance;
	assign commit   = vld_s1 && advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			clock_valid_s1 <= clock_valid;
			hour_s1        <= hour;
			minute_s1      <= minute;
			now_ms_s1      <= now_ms;
			relays_s1      <= relay_states;
		end
	end

	// Only the minute is compared to detect a new minute.
	assign new_minute = ({1'b0, minute_s1} != last_minute_q);

	// One lane per channel.
	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		drt_lane u_lane (
			.setup       (setup[i]),
			.limit       (limit[i]),
			.stamp       (stamp_q[i]),
			.clock_valid (clock_valid_s1),
			.new_minute  (new_minute),
			.hour        (hour_s1),
			.minute      (minute_s1),
			.now_ms      (now_ms_s1),
			.relay_on    (relays_s1[i]),
			.res         (res[i])
		);

		assign stamp_set[i] = res[i].stamp_set;
		assign stamp_clr[i] = res[i].stamp_clr;

		// Duration stamp of this channel.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stamp_q[i] <= '0;
			end else if (commit && res[i].stamp_set) begin
				stamp_q[i] <= now_ms_s1;
			end else if (commit && res[i].stamp_clr) begin
				stamp_q[i] <= '0;
			end
		end
	end

	// Last seen minute, taken from valid ticks only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_minute_q <= NO_MINUTE;
		end else if (commit && clock_valid_s1) begin
			last_minute_q <= {1'b0, minute_s1};
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			for (int i = 0; i < CHANNELS; i++) begin
				on_s2[i]  <= res[i].turn_on;
				off_s2[i] <= res[i].turn_off;
			end
		end
	end

	assign out_valid = vld_s2;
	assign turn_on   = on_s2;
	assign turn_off  = off_s2;

	// The input stage only holds an item back when it is full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1)
		else $error("input stall raised with an empty input stage");

	// A channel never both starts and stops its duration stamp on one tick.
	a_stamp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(stamp_set & stamp_clr) == '0)
		else $error("duration stamp set and cleared together");

	// An invalid tick leaves the last minute alone; the lanes give no stamp commands for it either.
	a_invalid_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !clock_valid_s1) |=> $stable(last_minute_q))
		else $error("invalid tick changed the last minute");

	// A result that is held back keeps its masks.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && out_stall) |=> (vld_s2 && $stable(on_s2) && $stable(off_s2)))
		else $error("stalled result changed");

endmodule

// ===== dv/tb_daily_relay_time_switch_unit.sv =====
// Self-checking testbench for the daily relay time switch: directed and random ticks.
module tb_daily_relay_time_switch_unit;
	import drt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS  = 8;
	localparam int CFG_IDX_W = $clog2(CHANNELS + 1);
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 6;
	localparam logic [21:0] DUR_MAX = 22'h3F_FFFF;

	// One tick as presented on the input channel.
	typedef struct packed {
		logic                clock_valid;
		logic [4:0]          hour;
		logic [5:0]          minute;
		logic [MS_W-1:0]     now_ms;
		logic [CHANNELS-1:0] relays;
	} tick_t;

	// Switching commands of one result item.
	typedef struct packed {
		logic [CHANNELS-1:0] turn_on;
		logic [CHANNELS-1:0] turn_off;
	} masks_t;

	// Relay switching predictor and store of the commands still awaited.
	class relay_book;
		setup_t          setups[CHANNELS];
		logic [6:0]      seen_minute;
		logic [MS_W-1:0] stamps[CHANNELS];
		masks_t          due[$];
		int              errors;

		function new();
			foreach (setups[i]) begin
				setups[i] = '0;
				stamps[i] = '0;
			end
			seen_minute = NO_MINUTE;
			errors = 0;
		endfunction

		// Writes to indexes past the last channel are dropped.
		function void write_setup(int idx, logic [SETUP_W-1:0] data);
			if (idx < CHANNELS) begin
				setups[idx] = data;
			end
		endfunction

		// A time of day hits only when the hour lies within the day.
		function bit clock_hits(logic [4:0] h, logic [5:0] m, logic [4:0] rh, logic [5:0] rm);
			return (h < HOURS_PER_DAY) && (h == rh) && (m == rm);
		endfunction

		// Works out the commands for an accepted tick and queues them.
		function masks_t note_tick(tick_t t);
			masks_t          m;
			setup_t          s;
			logic            lit;
			logic [MS_W-1:0] lim;
			m = '0;
			if (t.clock_valid) begin
				if ({1'b0, t.minute} == seen_minute) begin
					// Same minute: only running durations may expire.
					for (int i = 0; i < CHANNELS; i++) begin
						s = setups[i];
						lim = s.dur_sec * 32'd1000;
						if (s.enable && s.dur_mode && t.relays[i] && stamps[i] != '0 &&
								(t.now_ms - stamps[i]) >= lim) begin
							m.turn_off[i] = 1'b1;
							stamps[i] = '0;
						end
					end
				end else begin
					// New minute: start and end matches, no duration check.
					seen_minute = {1'b0, t.minute};
					for (int i = 0; i < CHANNELS; i++) begin
						s = setups[i];
						lit = t.relays[i];
						if (s.enable) begin
							if (clock_hits(t.hour, t.minute, s.start_hour, s.start_min) &&
									!lit) begin
								m.turn_on[i] = 1'b1;
								lit = 1'b1;
								if (s.dur_mode) begin
									stamps[i] = t.now_ms;
								end
							end
							if (!s.dur_mode && lit &&
									clock_hits(t.hour, t.minute, s.end_hour, s.end_min)) begin
								m.turn_off[i] = 1'b1;
							end
						end
					end
				end
			end
			due.push_back(m);
			return m;
		endfunction

		// Compares a result item with the oldest awaited one.
		function void check_result(logic [CHANNELS-1:0] got_on, logic [CHANNELS-1:0] got_off);
			masks_t want;
			if (due.size() == 0) begin
				$error("unexpected result item: turn_on %h turn_off %h", got_on, got_off);
				errors++;
				return;
			end
			want = due.pop_front();
			if (got_on !== want.turn_on) begin
				$error("turn_on mismatch: expected %h, actual %h", want.turn_on, got_on);
				errors++;
			end
			if (got_off !== want.turn_off) begin
				$error("turn_off mismatch: expected %h, actual %h", want.turn_off, got_off);
				errors++;
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SETUP_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 clock_valid;
	logic [4:0]           hour;
	logic [5:0]           minute;
	logic [MS_W-1:0]      now_ms;
	logic [CHANNELS-1:0]  relay_states;
	logic                 out_valid;
	logic                 out_stall;
	logic [CHANNELS-1:0]  turn_on;
	logic [CHANNELS-1:0]  turn_off;

	relay_book           book = new();
	logic [CHANNELS-1:0] relay_now = '0;
	bit                  quiet = 1'b0;
	bit                  long_hold = 1'b0;
	int                  idle_cycles = 0;
	int                  cur_h;
	int                  cur_m;
	logic [MS_W-1:0]     cur_ms;

	daily_relay_time_switch_unit #(
		.CHANNELS(CHANNELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.clock_valid(clock_valid),
		.hour(hour),
		.minute(minute),
		.now_ms(now_ms),
		.relay_states(relay_states),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.turn_on(turn_on),
		.turn_off(turn_off)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result items are checked as they are taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			book.check_result(turn_on, turn_off);
		end
	end

	// Watchdog: ends the run when no channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, none when quiet.
	initial begin
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	function automatic logic [SETUP_W-1:0] pack_setup(bit en, bit dur, int sh, int sm,
			int eh, int em, logic [21:0] sec);
		setup_t s;
		s.start_hour = 5'(sh);
		s.start_min  = 6'(sm);
		s.end_hour   = 5'(eh);
		s.end_min    = 6'(em);
		s.enable     = en;
		s.dur_mode   = dur;
		s.dur_sec    = sec;
		return s;
	endfunction

	function automatic tick_t make_tick(bit v, int h, int m, logic [MS_W-1:0] ms,
			logic [CHANNELS-1:0] rel);
		tick_t t;
		t.clock_valid = v;
		t.hour        = 5'(h);
		t.minute      = 6'(m);
		t.now_ms      = ms;
		t.relays      = rel;
		return t;
	endfunction

	// Random setup whose times mostly fall within the next half hour of the walk.
	function automatic logic [SETUP_W-1:0] pick_setup();
		setup_t s;
		int     a;
		int     b;
		s = setup_t'(46'({$urandom, $urandom}));
		if ($urandom_range(0, 9) != 0) begin
			a = $urandom_range(0, 30);
			b = ($urandom_range(0, 3) == 0) ? a : a + $urandom_range(0, 8);
			s.start_hour = 5'((cur_h % 24 + (cur_m + a) / 60) % 24);
			s.start_min  = 6'((cur_m + a) % 60);
			s.end_hour   = 5'((cur_h % 24 + (cur_m + b) / 60) % 24);
			s.end_min    = 6'((cur_m + b) % 60);
			s.enable     = ($urandom_range(0, 7) != 0);
			s.dur_mode   = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9)) inside
				0: s.dur_sec = 22'($urandom);
				1: s.dur_sec = DUR_MAX;
				2, 3: s.dur_sec = 22'($urandom_range(7, 40));
				default: s.dur_sec = 22'($urandom_range(0, 6));
			endcase
			if ($urandom_range(0, 19) == 0) begin
				s.start_hour = 5'($urandom_range(24, 31));
			end
		end
		return s;
	endfunction

	// Offers a register write and waits until it is taken; the caller lowers valid.
	task automatic write_reg(int idx, logic [SETUP_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		book.write_setup(idx, data);
	endtask

	// Offers a tick and waits until it is taken; valid stays high for the next one.
	task automatic send_tick(tick_t t);
		masks_t m;
		in_valid     <= 1'b1;
		clock_valid  <= t.clock_valid;
		hour         <= t.hour;
		minute       <= t.minute;
		now_ms       <= t.now_ms;
		relay_states <= t.relays;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		m = book.note_tick(t);
		relay_now = (relay_now | m.turn_on) & ~m.turn_off;
	endtask

	// Lowers valid, lets every awaited result arrive, then idles for a spare drain period.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Starts a fresh walk of the wall clock.
	task automatic start_walk();
		cur_h = $urandom_range(0, 23);
		cur_m = $urandom_range(0, 59);
		cur_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4095) : $urandom;
	endtask

	// Random ticks: mostly a walking clock with tracked relays, some noise.
	task automatic run_ticks(int count, bit hold);
		tick_t t;
		int    r;
		for (int n = 0; n < count; n++) begin
			if (hold && n == count / 3) begin
				long_hold = 1'b1;
			end
			if (!quiet && $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 12) begin
				t = tick_t'({$urandom, $urandom});
				t.minute = 6'($urandom_range(0, 63));
			end else begin
				if (r < 40) begin
					cur_m = cur_m + 1;
					if (cur_m == 60) begin
						cur_m = 0;
						cur_h = (cur_h + 1) % 24;
					end
				end else if (r < 43) begin
					// Hour moves while the minute stays put.
					cur_h = $urandom_range(0, 31);
				end
				if ($urandom_range(0, 29) == 0) begin
					cur_ms = cur_ms + $urandom;
				end else begin
					cur_ms = cur_ms + $urandom_range(0, 2500);
				end
				if ($urandom_range(0, 9) == 0) begin
					relay_now = relay_now ^ CHANNELS'($urandom_range(0, 255));
				end
				t = make_tick($urandom_range(0, 19) != 0, cur_h, cur_m, cur_ms, relay_now);
			end
			send_tick(t);
		end
	endtask

	initial begin
		tick_t script[$];
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		clock_valid  <= 1'b0;
		hour         <= '0;
		minute       <= '0;
		now_ms       <= '0;
		relay_states <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed settings: equal start and end, durations of zero, one and the maximum,
		// hours outside the day, minutes past 59 and a disabled channel.
		write_reg(0, pack_setup(1, 0, 0, 0, 0, 0, 0));
		write_reg(1, pack_setup(1, 1, 0, 0, 0, 0, 1));
		write_reg(2, pack_setup(1, 0, 23, 59, 0, 1, 0));
		write_reg(3, pack_setup(1, 0, 24, 0, 31, 63, 0));
		write_reg(4, pack_setup(0, 0, 0, 0, 0, 0, 0));
		write_reg(5, pack_setup(1, 1, 23, 59, 0, 0, DUR_MAX));
		write_reg(6, pack_setup(1, 0, 0, 60, 0, 63, 0));
		write_reg(7, pack_setup(1, 1, 0, 0, 0, 0, 0));
		cfg_valid <= 1'b0;
		@(posedge clk);

		// Invalid clock, a start at time zero, expiry, wrap of the counter and hour-only change.
		script.push_back(make_tick(0, 0, 0, 32'd0, 8'h00));
		script.push_back(make_tick(1, 0, 0, 32'd0, 8'h00));
		script.push_back(make_tick(1, 0, 0, 32'd5000, 8'hFF));
		script.push_back(make_tick(1, 0, 1, 32'd10, 8'h00));
		script.push_back(make_tick(1, 0, 0, 32'd100, 8'h00));
		script.push_back(make_tick(1, 0, 0, 32'd100, 8'hFF));
		script.push_back(make_tick(1, 0, 0, 32'd1099, 8'hFF));
		script.push_back(make_tick(1, 0, 0, 32'd1100, 8'hFF));
		script.push_back(make_tick(1, 23, 59, 32'hFFFF_FFFF, 8'h00));
		script.push_back(make_tick(1, 23, 59, 32'd100, 8'hFF));
		script.push_back(make_tick(1, 0, 60, 32'd7, 8'h00));
		script.push_back(make_tick(1, 0, 63, 32'd7, 8'hFF));
		script.push_back(make_tick(1, 31, 0, 32'd0, 8'h00));
		script.push_back(make_tick(1, 24, 0, 32'd0, 8'hFF));
		script.push_back(make_tick(1, 0, 1, 32'd123, 8'hFF));
		script.push_back(make_tick(0, 31, 63, 32'hFFFF_FFFF, 8'hFF));
		script.push_back(make_tick(1, 23, 59, 32'hF9FF_FC16, 8'hFF));
		script.push_back(make_tick(1, 23, 59, 32'hF9FF_FC16, 8'hFF));
		script.push_back(make_tick(1, 23, 59, 32'hF9FF_FC17, 8'hFF));
		foreach (script[i]) begin
			send_tick(script[i]);
		end
		settle();

		// Every register at all ones: out-of-day hours, maximum durations.
		start_walk();
		for (int i = 0; i < CHANNELS; i++) begin
			write_reg(i, {SETUP_W{1'b1}});
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
		run_ticks(40, 1'b0);
		settle();

		// Every register cleared; writes past the last channel must be dropped.
		start_walk();
		for (int i = 0; i < CHANNELS; i++) begin
			write_reg(i, '0);
		end
		write_reg(CHANNELS, pick_setup());
		write_reg(2 ** CFG_IDX_W - 1, {SETUP_W{1'b1}});
		cfg_valid <= 1'b0;
		@(posedge clk);
		run_ticks(40, 1'b0);
		settle();

		// Random settings per phase; the last two run without any idling.
		for (int p = 0; p < 10; p++) begin
			start_walk();
			for (int i = 0; i < CHANNELS; i++) begin
				write_reg(i, pick_setup());
			end
			cfg_valid <= 1'b0;
			@(posedge clk);
			quiet = (p >= 8);
			run_ticks(155, p == 3);
			settle();
		end

		if (book.errors == 0 && book.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/drt_pkg.sv
rtl/drt_setup.sv
rtl/drt_lane.sv
rtl/daily_relay_time_switch_unit.sv
dv/tb_daily_relay_time_switch_unit.sv
